// ===== rtl/mme_pkg.sv =====
// Shared types and constants for the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

   localparam int IDX_W  = 4;   // row / column index of the fields
   localparam int SIZE_W = 5;   // size registers
   localparam int VAL_W  = 16;  // Q8.8 element
   localparam int PROD_W = 32;  // Q16.16 product
   localparam int ACC_W  = 40;  // Q24.16 sum
   localparam int FIELD_DIM = 16;

   typedef enum logic [1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_COMPUTE = 2'd2
   } cmd_type;

   localparam logic [1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [1:0] CSR_COLS_B    = 2'd2;

   // Controls from the sequencer to the element store.
   typedef struct packed {
      logic a_we;
      logic b_we;
      logic rd_en;
   } store_ctl_type;

   // Controls from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctl_type;

endpackage

// ===== rtl/mme_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface mme_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         command;
   logic [mme_pkg::IDX_W-1:0]          row;
   logic [mme_pkg::IDX_W-1:0]          col;
   logic signed [mme_pkg::VAL_W-1:0]   value;

   modport source (output valid, command, row, col, value, input ready);
   modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface mme_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mme_pkg::IDX_W-1:0]          out_row;
   logic [mme_pkg::IDX_W-1:0]          out_col;
   logic signed [mme_pkg::ACC_W-1:0]   product;
   logic                               last;

   modport source (output valid, out_row, out_col, product, last, input ready);
   modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

// ===== rtl/mme_store.sv =====
// Element memories for matrices A and B, one write and one registered read each.
`timescale 1ns / 1ps

module mme_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mme_pkg::store_ctl_type             ctl,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic [mme_pkg::VAL_W-1:0]          wr_data,
   input  logic [ADDR_W-1:0]                  a_rd_addr,
   input  logic [ADDR_W-1:0]                  b_rd_addr,
   output logic signed [mme_pkg::VAL_W-1:0]   a_rd_data_ff,
   output logic signed [mme_pkg::VAL_W-1:0]   b_rd_data_ff,
   output logic                               rd_valid_ff
);
   import mme_pkg::*;

   logic [VAL_W-1:0] mem_a [DEPTH];
   logic [VAL_W-1:0] mem_b [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.a_we) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (ctl.b_we) begin
         mem_b[wr_addr] <= wr_data;
      end
      a_rd_data_ff <= mem_a[a_rd_addr];
      b_rd_data_ff <= mem_b[b_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctl.rd_en;
      end
   end

endmodule

// ===== rtl/mme_mac.sv =====
// Shared multiply-accumulate unit: registered 16x16 product, 40-bit exact sum.
`timescale 1ns / 1ps

module mme_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  mme_pkg::mac_ctl_type               ctl,
   input  logic signed [mme_pkg::VAL_W-1:0]   a,
   input  logic signed [mme_pkg::VAL_W-1:0]   b,
   output logic signed [mme_pkg::ACC_W-1:0]   acc_ff,
   output logic                               busy
);
   import mme_pkg::*;

   logic signed [PROD_W-1:0] product_ff;
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(product_ff);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= a * b;
      acc_ff     <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.valid;
      end
   end

   assign busy = prod_valid_ff;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
// Top level of the matrix multiply engine: size registers, sequencer, result register.
`timescale 1ns / 1ps

// Usage
//  req_chan  : valid/ready transactions carrying command, row, col, value.
//              Load A / load B write one element of the selected matrix; loads
//              outside the configured sizes are dropped. Compute asks for one
//              row of the product; a row outside rows_a gives nothing.
//  rsp_chan  : one transaction per product column, in column order, carrying
//              out_row, out_col, the exact Q24.16 product and last on the
//              final column of the row.
//  csr_*     : write-only size registers (rows_a, inner_dim, cols_b); the user
//              writes them only while the engine is idle; the block does not enforce it.
// Sequencing
//  A load is written into its store as it is accepted. A compute holds
//  req_chan.ready low until its last column is in the result register: every
//  term runs through the one shared multiply-accumulate unit, one per cycle,
//  followed by a drain of the memory read and product registers per column.
//  One result register decouples rsp_chan; if the receiver stalls, the
//  sequencer waits at the end of a column until that register frees up.
// Reset clears the control state and sets all sizes to 16; stored matrix
// elements are undefined until loaded.

module matrix_multiply_engine #(
   parameter int MAX_DIM = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   mme_req_if.sink                         req_chan,
   mme_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [mme_pkg::SIZE_W-1:0]      csr_data
);
   import mme_pkg::*;

   // Fields are 4 bits wide, so no more than 16 entries per dimension are usable.
   localparam int DIM    = (MAX_DIM < FIELD_DIM) ? MAX_DIM : FIELD_DIM;
   localparam int DEPTH  = DIM * DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Size registers
   logic [SIZE_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [SIZE_W-1:0] nr, nk, nc;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= SIZE_W'(16);
         inner_dim_ff <= SIZE_W'(16);
         cols_b_ff    <= SIZE_W'(16);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_data;
            CSR_INNER_DIM: inner_dim_ff <= csr_data;
            CSR_COLS_B:    cols_b_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective sizes, clamped to the storage
   assign nr = (rows_a_ff    > SIZE_W'(DIM)) ? SIZE_W'(DIM) : rows_a_ff;
   assign nk = (inner_dim_ff > SIZE_W'(DIM)) ? SIZE_W'(DIM) : inner_dim_ff;
   assign nc = (cols_b_ff    > SIZE_W'(DIM)) ? SIZE_W'(DIM) : cols_b_ff;

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      int lin;
      lin = int'(r) * DIM + int'(c);
      return ADDR_W'(lin);
   endfunction

   // Sequencer state and registered outputs
   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        row_ff, row_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [IDX_W-1:0]        j_ff, j_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]        rsp_col_ff, rsp_col_in;
   logic signed [ACC_W-1:0] rsp_prod_ff, rsp_prod_in;
   logic                    rsp_last_ff, rsp_last_in;

   store_ctl_type           store_ctl;
   mac_ctl_type             mac_ctl;
   logic [ADDR_W-1:0]       wr_addr, a_rd_addr, b_rd_addr;
   logic signed [VAL_W-1:0] a_data, b_data;
   logic                    rd_valid;
   logic signed [ACC_W-1:0] acc;
   logic                    mac_busy;

   logic                    req_take;
   logic                    rsp_free;
   logic                    row_ok, col_ok_a, col_ok_b, row_ok_b;
   logic                    last_k, last_j;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign row_ok   = {1'b0, req_chan.row} < nr;
   assign col_ok_a = {1'b0, req_chan.col} < nk;
   assign row_ok_b = {1'b0, req_chan.row} < nk;
   assign col_ok_b = {1'b0, req_chan.col} < nc;

   assign last_k = ({1'b0, k_ff} == nk - SIZE_W'(1)) || (nk == '0);
   assign last_j = ({1'b0, j_ff} == nc - SIZE_W'(1));

   assign wr_addr   = elem_addr(req_chan.row, req_chan.col);
   assign a_rd_addr = elem_addr(row_ff, k_ff);
   assign b_rd_addr = elem_addr(k_ff, j_ff);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_prod_in  = rsp_prod_ff;
      rsp_last_in  = rsp_last_ff;
      store_ctl    = '0;
      mac_ctl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_chan.command)
                  CMD_LOAD_A:  store_ctl.a_we = row_ok && col_ok_a;
                  CMD_LOAD_B:  store_ctl.b_we = row_ok_b && col_ok_b;
                  CMD_COMPUTE: begin
                     if (row_ok && nc != '0) begin
                        row_in        = req_chan.row;
                        k_in          = '0;
                        j_in          = '0;
                        mac_ctl.clear = 1'b1;
                        state_in      = ST_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            // One term of the dot product per cycle
            store_ctl.rd_en = (nk != '0);
            if (last_k) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // Wait for the read and product stages to empty and the result register to free, then hand off
            if (!rd_valid && !mac_busy && rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_col_in   = j_ff;
               rsp_prod_in  = acc;
               rsp_last_in  = last_j;
               if (last_j) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in          = j_ff + IDX_W'(1);
                  mac_ctl.clear = 1'b1;
                  state_in      = ST_RUN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      mac_ctl.valid = rd_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
      end
      row_ff      <= row_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_prod_ff <= rsp_prod_in;
      rsp_last_ff <= rsp_last_in;
   end

   mme_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .ctl          (store_ctl),
      .wr_addr      (wr_addr),
      .wr_data      (req_chan.value),
      .a_rd_addr    (a_rd_addr),
      .b_rd_addr    (b_rd_addr),
      .a_rd_data_ff (a_data),
      .b_rd_data_ff (b_data),
      .rd_valid_ff  (rd_valid)
   );

   mme_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .a      (a_data),
      .b      (b_data),
      .acc_ff (acc),
      .busy   (mac_busy)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.out_row = rsp_row_ff;
   assign rsp_chan.out_col = rsp_col_ff;
   assign rsp_chan.product = rsp_prod_ff;
   assign rsp_chan.last    = rsp_last_ff;

endmodule

// ===== verif/matrix_multiply_engine_tb.sv =====
// Self-checking testbench for matrix_multiply_engine: loads, row computes, checks every dot product.
`timescale 1ns / 1ps

module matrix_multiply_engine_tb;
   import mme_pkg::*;

   localparam int MAX_DIM = 16;
   localparam int DRAIN_CYCLES = 50;     // covers a compute that yields no element
   localparam int LONG_HOLD = 400;       // receiver back-pressure stretch
   localparam int TARGET_ITEMS = 380;    // lower bound on transactions queued in total
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // One request transaction; hold makes the driver wait for all results first.
   typedef struct {
      logic [1:0]       command;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
      bit               hold;
   } req_txn_type;

   // One element of a product row.
   typedef struct {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [ACC_W-1:0] product;
      logic                    last;
   } dot_elem_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [SIZE_W-1:0] csr_data;

   mme_req_if req_if ();
   mme_rsp_if rsp_if ();

   matrix_multiply_engine #(
      .MAX_DIM (MAX_DIM)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------------
   req_txn_type  pending_requests[$];
   dot_elem_type awaited_dots[$];
   req_txn_type  live_txn;
   dot_elem_type head_dot;

   int  items_pushed = 0;
   int  items_accepted = 0;
   int  dots_seen = 0;
   int  failures = 0;
   int  phase_count = 0;
   bit  drain_next = 1'b0;
   bit  long_hold_done = 1'b0;
   int  hold_left = 0;

   // Size registers as the engine holds them, and their clamped values.
   logic [SIZE_W-1:0] cfg_rows = 5'd16;
   logic [SIZE_W-1:0] cfg_inner = 5'd16;
   logic [SIZE_W-1:0] cfg_cols = 5'd16;
   int eff_rows = 16;
   int eff_inner = 16;
   int eff_cols = 16;

   // Predicted element stores.
   logic signed [VAL_W-1:0] a_mem[MAX_DIM*MAX_DIM];
   logic signed [VAL_W-1:0] b_mem[MAX_DIM*MAX_DIM];

   // Entries already written, as seen by the stimulus generator. A compute is
   // only issued once every entry it reads has been loaded.
   bit gen_a_set[MAX_DIM*MAX_DIM];
   bit gen_b_set[MAX_DIM*MAX_DIM];

   // No random idling on either side over this window of accepted transactions.
   logic calm;
   assign calm = (items_accepted >= 150) && (items_accepted < 260);

   // ---------------------------------------------------------------------------
   // Clock, reset, known values at time zero
   // ---------------------------------------------------------------------------
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.command = CMD_LOAD_A;
      req_if.row = '0;
      req_if.col = '0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ROWS_A;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------
   function automatic int eff_size(input logic [SIZE_W-1:0] size_reg);
      int v;
      v = size_reg;
      if (v > MAX_DIM) v = MAX_DIM;
      if (v > FIELD_DIM) v = FIELD_DIM;
      return v;
   endfunction

   // Update the element stores for a load, or queue one dot product per
   // column for a compute whose row lies inside rows_a.
   function automatic void apply_request(input req_txn_type txn);
      logic signed [63:0] acc;
      dot_elem_type       elem;
      case (txn.command)
         CMD_LOAD_A: begin
            if (txn.row < eff_rows && txn.col < eff_inner)
               a_mem[txn.row * MAX_DIM + txn.col] = txn.value;
         end
         CMD_LOAD_B: begin
            if (txn.row < eff_inner && txn.col < eff_cols)
               b_mem[txn.row * MAX_DIM + txn.col] = txn.value;
         end
         CMD_COMPUTE: begin
            if (txn.row < eff_rows) begin
               for (int j = 0; j < eff_cols; j++) begin
                  acc = '0;
                  for (int k = 0; k < eff_inner; k++)
                     acc = acc + a_mem[txn.row * MAX_DIM + k] * b_mem[k * MAX_DIM + j];
                  elem.out_row = txn.row;
                  elem.out_col = j[IDX_W-1:0];
                  elem.product = acc[ACC_W-1:0];
                  elem.last = (j + 1 == eff_cols);
                  awaited_dots.push_back(elem);
               end
            end
         end
         default: ;  // unknown command: ignored
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: presents queued transactions, idles at random, honors hold
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            apply_request(live_txn);
            items_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() > 0
                && !(pending_requests[0].hold && awaited_dots.size() > 0)
                && (calm || $urandom_range(0, 99) >= 10)) begin
               live_txn = pending_requests.pop_front();
               req_if.valid <= 1'b1;
               req_if.command <= live_txn.command;
               req_if.row <= live_txn.row;
               req_if.col <= live_txn.col;
               req_if.value <= live_txn.value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver ready: random stalls plus one long hold once results flow
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!long_hold_done && dots_seen >= 30) begin
         // engine backs up while the driver keeps offering transactions
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(0, 99) >= 10);
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: every result against the oldest awaited dot product
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         dots_seen++;
         if (awaited_dots.size() == 0) begin
            $error("unexpected result: row %0d col %0d product %0d",
                   rsp_if.out_row, rsp_if.out_col, rsp_if.product);
            failures++;
         end else begin
            head_dot = awaited_dots.pop_front();
            if (rsp_if.out_row !== head_dot.out_row) begin
               $error("out_row: expected %0d, got %0d", head_dot.out_row, rsp_if.out_row);
               failures++;
            end
            if (rsp_if.out_col !== head_dot.out_col) begin
               $error("out_col: expected %0d, got %0d", head_dot.out_col, rsp_if.out_col);
               failures++;
            end
            if (rsp_if.product !== head_dot.product) begin
               $error("product: expected %0d, got %0d", head_dot.product, rsp_if.product);
               failures++;
            end
            if (rsp_if.last !== head_dot.last) begin
               $error("last: expected %0d, got %0d", head_dot.last, rsp_if.last);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------------
   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return VAL_W'($urandom());
      endcase
   endfunction

   // Queue one transaction; loads inside the sizes mark their entry written,
   // and only transactions the engine acts on count toward the budgets.
   task automatic push_item(input logic [1:0] command, input int row, input int col,
                            input logic [VAL_W-1:0] value);
      req_txn_type txn;
      bit          effective;
      txn.command = command;
      txn.row = 4'(row);
      txn.col = 4'(col);
      txn.value = value;
      txn.hold = drain_next;
      drain_next = 1'b0;
      effective = 1'b0;
      if (command == CMD_LOAD_A && row < eff_rows && col < eff_inner) begin
         effective = 1'b1;
         gen_a_set[row * MAX_DIM + col] = 1'b1;
      end
      if (command == CMD_LOAD_B && row < eff_inner && col < eff_cols) begin
         effective = 1'b1;
         gen_b_set[row * MAX_DIM + col] = 1'b1;
      end
      if (command == CMD_COMPUTE && row < eff_rows)
         effective = 1'b1;
      pending_requests.push_back(txn);
      items_pushed++;
      if (effective)
         phase_count++;
   endtask

   // Well-formed sequence: load what row r still lacks (and refresh a few
   // entries with new content), then compute it. r must be inside rows_a.
   task automatic emit_row(input int r);
      for (int k = 0; k < eff_inner; k++)
         if (!gen_a_set[r * MAX_DIM + k] || $urandom_range(0, 3) == 0)
            push_item(CMD_LOAD_A, r, k, rand_value());
      for (int k = 0; k < eff_inner; k++)
         for (int j = 0; j < eff_cols; j++)
            if (!gen_b_set[k * MAX_DIM + j] || $urandom_range(0, 9) == 0)
               push_item(CMD_LOAD_B, k, j, rand_value());
      push_item(CMD_COMPUTE, r, $urandom_range(0, 15), rand_value());
   endtask

   // Wait until every transaction is in and every result is out, then let
   // the engine finish any compute that produced nothing.
   task automatic wait_idle();
      do @(posedge clock);
      while (items_accepted != items_pushed || awaited_dots.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [SIZE_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      case (index)
         CSR_ROWS_A:    cfg_rows = data;
         CSR_INNER_DIM: cfg_inner = data;
         CSR_COLS_B:    cfg_cols = data;
         default: ;     // unknown index: no register
      endcase
      eff_rows = eff_size(cfg_rows);
      eff_inner = eff_size(cfg_inner);
      eff_cols = eff_size(cfg_cols);
   endtask

   task automatic set_sizes(input int rows, input int inner, input int cols);
      write_reg(CSR_ROWS_A, 5'(rows));
      write_reg(CSR_INNER_DIM, 5'(inner));
      write_reg(CSR_COLS_B, 5'(cols));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One random phase: mostly well-formed row sequences, the rest stray loads,
   // random-row computes (often out of range) and unknown commands.
   task automatic run_phase(input int rows, input int inner, input int cols, input int budget);
      int n;
      int r;
      int choice;
      wait_idle();
      set_sizes(rows, inner, cols);
      phase_count = 0;
      n = 0;
      while (phase_count < budget && n < 4 * budget) begin
         drain_next = (n == 10) || ($urandom_range(0, 39) == 0);
         choice = $urandom_range(0, 99);
         if (choice < 65) begin
            if (eff_rows > 0)
               emit_row($urandom_range(0, eff_rows - 1));
            else
               push_item(CMD_COMPUTE, $urandom_range(0, 15), 0, rand_value());
         end else if (choice < 82) begin
            push_item($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                      $urandom_range(0, 15), $urandom_range(0, 15), rand_value());
         end else if (choice < 92) begin
            r = $urandom_range(0, 15);
            if (r < eff_rows)
               emit_row(r);
            else
               push_item(CMD_COMPUTE, r, $urandom_range(0, 15), rand_value());
         end else begin
            push_item(CMD_UNKNOWN, $urandom_range(0, 15), $urandom_range(0, 15), rand_value());
         end
         n++;
      end
   endtask

   initial begin : stimulus
      wait (reset == 1'b0);
      @(posedge clock);

      // Directed: 2x2 by 2x2 with full-scale operands, giving sums of two
      // extreme products; plus an unknown register
      // index, out-of-range loads and computes, and an unknown command.
      write_reg(CSR_ROWS_A, 5'd2);
      write_reg(CSR_INNER_DIM, 5'd2);
      write_reg(CSR_COLS_B, 5'd2);
      write_reg(CSR_UNUSED, 5'd7);
      @(posedge clock);
      csr_we <= 1'b0;
      push_item(CMD_LOAD_A, 0, 0, 16'h8000);
      push_item(CMD_LOAD_A, 0, 1, 16'h7FFF);
      push_item(CMD_LOAD_A, 1, 0, 16'h7FFF);
      push_item(CMD_LOAD_A, 1, 1, 16'h8000);
      push_item(CMD_LOAD_B, 0, 0, 16'h8000);
      push_item(CMD_LOAD_B, 0, 1, 16'h7FFF);
      push_item(CMD_LOAD_B, 1, 0, 16'h8000);
      push_item(CMD_LOAD_B, 1, 1, 16'h8000);
      push_item(CMD_COMPUTE, 0, 15, 16'hFFFF);
      push_item(CMD_COMPUTE, 1, 0, 16'h0000);
      push_item(CMD_LOAD_A, 1, 2, 16'h1234);     // column beyond inner_dim
      push_item(CMD_LOAD_B, 2, 0, 16'h4321);     // row beyond inner_dim
      push_item(CMD_LOAD_A, 15, 15, 16'hFFFF);
      push_item(CMD_COMPUTE, 2, 0, 16'h0000);    // row beyond rows_a
      push_item(CMD_COMPUTE, 15, 15, 16'hFFFF);
      push_item(CMD_UNKNOWN, 15, 15, 16'hFFFF);
      push_item(CMD_COMPUTE, 1, 5, 16'h5555);    // stores untouched by ignored loads

      // Fixed settings: empty dimensions, maxima, values past the field range.
      run_phase(3, 3, 3, 40);
      run_phase(0, 4, 4, 12);     // no product rows
      run_phase(4, 0, 4, 12);     // empty inner dimension: all products zero
      run_phase(4, 4, 0, 12);     // no product columns
      run_phase(16, 1, 16, 40);
      run_phase(31, 16, 1, 50);   // rows register past the clamp
      run_phase(16, 16, 2, 50);
      run_phase(1, 1, 1, 25);
      run_phase(5, 3, 7, 50);

      // Random small settings until the item count is reached.
      while (items_pushed < TARGET_ITEMS)
         run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6), 40);

      wait_idle();
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mme_pkg.sv
rtl/mme_if.sv
rtl/mme_store.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine.sv
verif/matrix_multiply_engine_tb.sv
